// File: sv/tpi_pkg.sv
// Shared constants, index codes and term tables for the three-plane intersection block.
package tpi_pkg;

   localparam int COEF_BITS_DEFAULT = 21;
   localparam int RES_BITS          = 64;
   localparam int NUM_COLS          = 4;
   localparam int NUM_COEF          = 12;
   localparam int NUM_MINORS        = 6;
   localparam int NUM_DETS          = 4;
   localparam int TERMS_PER_DET     = 3;
   localparam int NUM_TERMS         = NUM_DETS * TERMS_PER_DET;

   // Column of a plane equation: a, b, c and the right-hand constant d.
   typedef enum logic [1:0] {COL_A, COL_B, COL_C, COL_D} col_type;

   // 2x2 minors of the second and third planes over an ordered column pair.
   typedef enum logic [2:0] {MIN_AB, MIN_AC, MIN_AD, MIN_BC, MIN_BD, MIN_CD} minor_type;

   // Order of the determinants in the result.
   typedef enum logic [1:0] {DET_X, DET_Y, DET_Z, DET_WEIGHT} det_type;

   // Minor m is u1*v2 - v1*u2 for the column pair (MINOR_U[m], MINOR_V[m]).
   localparam col_type MINOR_U [NUM_MINORS] = '{COL_A, COL_A, COL_A, COL_B, COL_B, COL_C};
   localparam col_type MINOR_V [NUM_MINORS] = '{COL_B, COL_C, COL_D, COL_C, COL_D, COL_D};

   // Each determinant is expanded along the first plane; term t belongs to
   // determinant t / TERMS_PER_DET and is +/- first_col * minor.
   localparam col_type TERM_COL [NUM_TERMS] = '{
      COL_D, COL_B, COL_C,
      COL_A, COL_D, COL_C,
      COL_A, COL_B, COL_D,
      COL_A, COL_B, COL_C};
   localparam minor_type TERM_MINOR [NUM_TERMS] = '{
      MIN_BC, MIN_CD, MIN_BD,
      MIN_CD, MIN_AC, MIN_AD,
      MIN_BD, MIN_AD, MIN_AB,
      MIN_BC, MIN_AC, MIN_AB};
   localparam bit TERM_NEG [NUM_TERMS] = '{
      1'b0, 1'b0, 1'b1,
      1'b1, 1'b1, 1'b0,
      1'b0, 1'b1, 1'b0,
      1'b0, 1'b1, 1'b0};

   function automatic int coef_index(input int plane, input int col);
      return plane * NUM_COLS + col;
   endfunction

endpackage

// File: sv/three_plane_intersection.sv
// Top level of the three-plane intersection block: stream ports and the six-stage pipeline.
//
// Each transfer on the req_ channel carries three planes a*x + b*y + c*z = d as twelve
// signed coefficients. The block answers each with one transfer on the rsp_ channel: the
// exact homogeneous intersection point by Cramer's rule (three numerator determinants and
// the common weight determinant, each sign-extended to 64 bits) and, in rsp_tuser, a flag
// that is set when the weight is nonzero, i.e. the planes meet in a single point.
// The pipeline takes one item in every cycle unless all stages are full and rsp_tready
// is low. The six stages are 2x2 cross products, minors, split coefficient-by-minor
// products, term recombination, a partial sum and the final sum with the zero test.
// Each stage holds one item with its own valid bit, and ready travels backwards stage by
// stage, so when the receiver holds rsp_tready low the result waits in the output stage
// while earlier stages keep filling any empty slots; req_tready falls only once every stage
// holds an item. Nothing is dropped or repeated under back-pressure.
// Reset is synchronous and active high; it empties all stages. Input bits above the
// twelve packed coefficients are ignored.
module three_plane_intersection
   import tpi_pkg::*;
#(
   parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // first_a, first_b, first_c, first_d, second_a .. second_d, third_a .. third_d,
   // COEF_BITS each from the lowest bit up, padded to whole bytes
   input  logic [((NUM_COEF*COEF_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // x_numerator, y_numerator, z_numerator, weight, 64 bits each from the lowest bit up
   output logic [NUM_DETS*RES_BITS-1:0]                rsp_tdata,
   // unique_res
   output logic                                        rsp_tuser
);

   localparam int MINOR_BITS = 2 * COEF_BITS + 1;
   localparam int DET_BITS   = 3 * COEF_BITS + 1;

   logic signed [COEF_BITS-1:0]  coef [NUM_COEF];
   logic                         mnr_valid, mnr_ready, trm_valid, trm_ready;
   logic signed [COEF_BITS-1:0]  mnr_row0 [NUM_COLS];
   logic signed [MINOR_BITS-1:0] mnr_minor [NUM_MINORS];
   logic signed [DET_BITS-1:0]   trm_term [NUM_TERMS];
   logic signed [DET_BITS-1:0]   det [NUM_DETS];

   always_comb begin
      for (int n = 0; n < NUM_COEF; n++) begin
         coef[n] = $signed(req_tdata[n*COEF_BITS +: COEF_BITS]);
      end
   end

   tpi_minor #(.COEF_BITS(COEF_BITS)) u_minor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_coef   (coef),
      .out_valid (mnr_valid),
      .out_ready (mnr_ready),
      .out_row0  (mnr_row0),
      .out_minor (mnr_minor)
   );

   tpi_term #(.COEF_BITS(COEF_BITS)) u_term (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mnr_valid),
      .in_ready  (mnr_ready),
      .in_row0   (mnr_row0),
      .in_minor  (mnr_minor),
      .out_valid (trm_valid),
      .out_ready (trm_ready),
      .out_term  (trm_term)
   );

   // The final stage of this unit is the output register of the block.
   tpi_sum #(.COEF_BITS(COEF_BITS)) u_sum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (trm_valid),
      .in_ready   (trm_ready),
      .in_term    (trm_term),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_det    (det),
      .out_unique (rsp_tuser)
   );

   // Sign-extend each determinant to the full result width.
   always_comb begin
      for (int k = 0; k < NUM_DETS; k++) begin
         rsp_tdata[k*RES_BITS +: RES_BITS] = RES_BITS'(det[k]);
      end
   end

   // The flag must agree with the weight it describes.
   a_unique_matches_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[int'(DET_WEIGHT)*RES_BITS +: RES_BITS] != '0)))
      else $error("unique flag disagrees with weight");

   // With the output stage empty every stage can move, so the input must be open.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked while output stage is empty");

   // Reset empties the pipeline.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");

endmodule

// File: sv/tpi_minor.sv
// Stages one and two: cross products of the second and third planes and their 2x2 minors.
module tpi_minor
   import tpi_pkg::*;
#(
   parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [COEF_BITS-1:0] in_coef [NUM_COEF],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [COEF_BITS-1:0] out_row0 [NUM_COLS],
   output logic signed [2*COEF_BITS:0] out_minor [NUM_MINORS]
);

   localparam int PROD_BITS  = 2 * COEF_BITS;
   localparam int MINOR_BITS = 2 * COEF_BITS + 1;

   logic                         s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic                         s1_ready, s2_ready;
   logic signed [PROD_BITS-1:0]  s1_prod_ff [2*NUM_MINORS];
   logic signed [PROD_BITS-1:0]  s1_prod_in [2*NUM_MINORS];
   logic signed [COEF_BITS-1:0]  s1_row0_ff [NUM_COLS];
   logic signed [COEF_BITS-1:0]  s2_row0_ff [NUM_COLS];
   logic signed [MINOR_BITS-1:0] s2_minor_ff [NUM_MINORS];
   logic signed [MINOR_BITS-1:0] s2_minor_in [NUM_MINORS];

   // A stage takes a new item when it is empty or its content moves on.
   assign s2_ready = !s2_vld_ff || out_ready;
   assign s1_ready = !s1_vld_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      for (int m = 0; m < NUM_MINORS; m++) begin
         s1_prod_in[2*m]   = PROD_BITS'(in_coef[coef_index(1, MINOR_U[m])])
                           * PROD_BITS'(in_coef[coef_index(2, MINOR_V[m])]);
         s1_prod_in[2*m+1] = PROD_BITS'(in_coef[coef_index(1, MINOR_V[m])])
                           * PROD_BITS'(in_coef[coef_index(2, MINOR_U[m])]);
         s2_minor_in[m]    = MINOR_BITS'(s1_prod_ff[2*m]) - MINOR_BITS'(s1_prod_ff[2*m+1]);
      end
      s1_vld_in = s1_ready ? in_valid : s1_vld_ff;
      s2_vld_in = s2_ready ? s1_vld_ff : s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_prod_ff <= s1_prod_in;
         for (int c = 0; c < NUM_COLS; c++) begin
            s1_row0_ff[c] <= in_coef[coef_index(0, c)];
         end
      end
      if (s2_ready && s1_vld_ff) begin
         s2_minor_ff <= s2_minor_in;
         s2_row0_ff  <= s1_row0_ff;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_row0  = s2_row0_ff;
   assign out_minor = s2_minor_ff;

endmodule

// File: sv/tpi_term.sv
// Stages three and four: signed first-plane coefficient times minor, split into two narrow products and recombined.
module tpi_term
   import tpi_pkg::*;
#(
   parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [COEF_BITS-1:0] in_row0 [NUM_COLS],
   input  logic signed [2*COEF_BITS:0] in_minor [NUM_MINORS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [3*COEF_BITS:0] out_term [NUM_TERMS]
);

   localparam int MINOR_BITS   = 2 * COEF_BITS + 1;
   localparam int NEG_BITS     = COEF_BITS + 1;
   localparam int LO_BITS      = COEF_BITS + 1;
   localparam int HI_BITS      = MINOR_BITS - LO_BITS;
   localparam int LO_PROD_BITS = NEG_BITS + LO_BITS + 1;
   localparam int HI_PROD_BITS = NEG_BITS + HI_BITS;
   localparam int DET_BITS     = 3 * COEF_BITS + 1;

   logic                           s3_vld_ff, s3_vld_in, s4_vld_ff, s4_vld_in;
   logic                           s3_ready, s4_ready;
   logic signed [NEG_BITS-1:0]     coef_sgn [NUM_TERMS];
   logic signed [LO_BITS:0]        minor_lo [NUM_TERMS];
   logic signed [HI_BITS-1:0]      minor_hi [NUM_TERMS];
   logic signed [LO_PROD_BITS-1:0] s3_lo_ff [NUM_TERMS];
   logic signed [LO_PROD_BITS-1:0] s3_lo_in [NUM_TERMS];
   logic signed [HI_PROD_BITS-1:0] s3_hi_ff [NUM_TERMS];
   logic signed [HI_PROD_BITS-1:0] s3_hi_in [NUM_TERMS];
   logic signed [DET_BITS-1:0]     s4_term_ff [NUM_TERMS];
   logic signed [DET_BITS-1:0]     s4_term_in [NUM_TERMS];

   assign s4_ready = !s4_vld_ff || out_ready;
   assign s3_ready = !s3_vld_ff || s4_ready;
   assign in_ready = s3_ready;

   // The minor is cut into an unsigned low part and a signed high part so that
   // neither product is wider than the coefficient by about its own width.
   always_comb begin
      for (int t = 0; t < NUM_TERMS; t++) begin
         coef_sgn[t]   = TERM_NEG[t] ? -NEG_BITS'(in_row0[TERM_COL[t]])
                                     :  NEG_BITS'(in_row0[TERM_COL[t]]);
         minor_lo[t]   = $signed({1'b0, in_minor[TERM_MINOR[t]][LO_BITS-1:0]});
         minor_hi[t]   = $signed(in_minor[TERM_MINOR[t]][MINOR_BITS-1:LO_BITS]);
         s3_lo_in[t]   = LO_PROD_BITS'(coef_sgn[t]) * LO_PROD_BITS'(minor_lo[t]);
         s3_hi_in[t]   = HI_PROD_BITS'(coef_sgn[t]) * HI_PROD_BITS'(minor_hi[t]);
         s4_term_in[t] = (DET_BITS'(s3_hi_ff[t]) <<< LO_BITS) + DET_BITS'(s3_lo_ff[t]);
      end
      s3_vld_in = s3_ready ? in_valid : s3_vld_ff;
      s4_vld_in = s4_ready ? s3_vld_ff : s4_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_lo_ff <= s3_lo_in;
         s3_hi_ff <= s3_hi_in;
      end
      if (s4_ready && s3_vld_ff) begin
         s4_term_ff <= s4_term_in;
      end
   end

   assign out_valid = s4_vld_ff;
   assign out_term  = s4_term_ff;

endmodule

// File: sv/tpi_sum.sv
// Stages five and six: sums the three terms of each determinant and flags a nonzero weight.
module tpi_sum
   import tpi_pkg::*;
#(
   parameter int COEF_BITS = COEF_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [3*COEF_BITS:0] in_term [NUM_TERMS],
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [3*COEF_BITS:0] out_det [NUM_DETS],
   output logic                        out_unique
);

   localparam int DET_BITS = 3 * COEF_BITS + 1;

   logic                       s5_vld_ff, s5_vld_in, s6_vld_ff, s6_vld_in;
   logic                       s5_ready, s6_ready;
   logic signed [DET_BITS-1:0] s5_part_ff [NUM_DETS];
   logic signed [DET_BITS-1:0] s5_part_in [NUM_DETS];
   logic signed [DET_BITS-1:0] s5_last_ff [NUM_DETS];
   logic signed [DET_BITS-1:0] s6_det_ff [NUM_DETS];
   logic signed [DET_BITS-1:0] s6_det_in [NUM_DETS];
   logic                       s6_unique_ff, s6_unique_in;

   assign s6_ready = !s6_vld_ff || out_ready;
   assign s5_ready = !s5_vld_ff || s6_ready;
   assign in_ready = s5_ready;

   always_comb begin
      for (int k = 0; k < NUM_DETS; k++) begin
         s5_part_in[k] = in_term[k*TERMS_PER_DET] + in_term[k*TERMS_PER_DET+1];
         s6_det_in[k]  = s5_part_ff[k] + s5_last_ff[k];
      end
      s6_unique_in = (s6_det_in[DET_WEIGHT] != '0);
      s5_vld_in    = s5_ready ? in_valid : s5_vld_ff;
      s6_vld_in    = s6_ready ? s5_vld_ff : s6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s5_vld_in;
         s6_vld_ff <= s6_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && in_valid) begin
         s5_part_ff <= s5_part_in;
         for (int k = 0; k < NUM_DETS; k++) begin
            s5_last_ff[k] <= in_term[k*TERMS_PER_DET+2];
         end
      end
      if (s6_ready && s5_vld_ff) begin
         s6_det_ff    <= s6_det_in;
         s6_unique_ff <= s6_unique_in;
      end
   end

   assign out_valid  = s6_vld_ff;
   assign out_det    = s6_det_ff;
   assign out_unique = s6_unique_ff;

endmodule

// File: sim/three_plane_intersection_tb.sv
// Self-checking testbench for the three-plane intersection block.
module three_plane_intersection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpi_pkg::*;

   // The block is checked at its widest coefficient setting. Below that width a
   // determinant can always be held exactly in 64 bits, so nothing new is shown.
   localparam int COEF_BITS  = COEF_BITS_DEFAULT;
   localparam int COEFS_W    = NUM_COEF * COEF_BITS;
   localparam int TDATA_W    = ((COEFS_W + 7) / 8) * 8;
   localparam int PAD_W      = TDATA_W - COEFS_W;
   localparam int CMAX       = (1 << (COEF_BITS - 1)) - 1;
   localparam int CMIN       = -(1 << (COEF_BITS - 1));
   localparam int LATENCY    = 6;
   localparam int IDLE_PCT   = 36;
   // Allowed run of cycles with no transfer on either channel. This is far longer
   // than any random gap or stall, and longer than a full pipeline drain.
   localparam int STALL_LIMIT = 4000;

   // Twelve coefficients, packed as on req_tdata: first_a in the lowest bits.
   typedef logic [NUM_COEF-1:0][COEF_BITS-1:0] coef_set_type;

   // One intersection result. Members are listed from the top bit down, so
   // x_num sits in the lowest bits, as it does on rsp_tdata.
   typedef struct packed {
      logic                       unique_pt;
      logic signed [RES_BITS-1:0] weight;
      logic signed [RES_BITS-1:0] z_num;
      logic signed [RES_BITS-1:0] y_num;
      logic signed [RES_BITS-1:0] x_num;
   } hom_point_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // first_a .. first_d, second_a .. second_d, third_a .. third_d, then fill bits
   logic [TDATA_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // x_numerator, y_numerator, z_numerator, weight
   logic [NUM_DETS*RES_BITS-1:0] rsp_tdata;
   // unique_res
   logic                  rsp_tuser;

   hom_point_type expected_points[$];
   int            fault_count = 0;
   int            quiet_cycles = 0;
   bit            steady_flow = 1'b0;

   three_plane_intersection #(
      .COEF_BITS(COEF_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Determinant of a row-major 3x3 matrix, expanded along its first row.
   // With entries of at most 2^20 in magnitude the sum stays well inside 64 bits.
   function automatic longint det3(longint m0, longint m1, longint m2,
                                   longint m3, longint m4, longint m5,
                                   longint m6, longint m7, longint m8);
      return m0 * (m4 * m8 - m5 * m7)
           - m1 * (m3 * m8 - m5 * m6)
           + m2 * (m3 * m7 - m4 * m6);
   endfunction

   // Cramer's rule on the three planes: the weight is the determinant of the
   // a, b, c columns, and each numerator swaps the d column in for one of them.
   function automatic hom_point_type intersect_planes(coef_set_type k);
      longint        a[3], b[3], c[3], d[3];
      hom_point_type pt;
      int            p;
      for (p = 0; p < 3; p++) begin
         a[p] = $signed(k[p*NUM_COLS + COL_A]);
         b[p] = $signed(k[p*NUM_COLS + COL_B]);
         c[p] = $signed(k[p*NUM_COLS + COL_C]);
         d[p] = $signed(k[p*NUM_COLS + COL_D]);
      end
      pt.x_num  = det3(d[0], b[0], c[0], d[1], b[1], c[1], d[2], b[2], c[2]);
      pt.y_num  = det3(a[0], d[0], c[0], a[1], d[1], c[1], a[2], d[2], c[2]);
      pt.z_num  = det3(a[0], b[0], d[0], a[1], b[1], d[1], a[2], b[2], d[2]);
      pt.weight = det3(a[0], b[0], c[0], a[1], b[1], c[1], a[2], b[2], c[2]);
      pt.unique_pt = (pt.weight != 0);
      return pt;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Builds a triple from three rows of a, b, c, d. Values are cut to the
   // coefficient width, so hex bit patterns may be given as well as integers.
   function automatic coef_set_type planes(int a1, int b1, int c1, int d1,
                                           int a2, int b2, int c2, int d2,
                                           int a3, int b3, int c3, int d3);
      coef_set_type k;
      k[0*NUM_COLS + COL_A] = a1[COEF_BITS-1:0];
      k[0*NUM_COLS + COL_B] = b1[COEF_BITS-1:0];
      k[0*NUM_COLS + COL_C] = c1[COEF_BITS-1:0];
      k[0*NUM_COLS + COL_D] = d1[COEF_BITS-1:0];
      k[1*NUM_COLS + COL_A] = a2[COEF_BITS-1:0];
      k[1*NUM_COLS + COL_B] = b2[COEF_BITS-1:0];
      k[1*NUM_COLS + COL_C] = c2[COEF_BITS-1:0];
      k[1*NUM_COLS + COL_D] = d2[COEF_BITS-1:0];
      k[2*NUM_COLS + COL_A] = a3[COEF_BITS-1:0];
      k[2*NUM_COLS + COL_B] = b3[COEF_BITS-1:0];
      k[2*NUM_COLS + COL_C] = c3[COEF_BITS-1:0];
      k[2*NUM_COLS + COL_D] = d3[COEF_BITS-1:0];
      return k;
   endfunction

   // A random coefficient. Most are uniform over the whole field so that every
   // bit toggles; the rest favour the extremes, powers of two and small values,
   // where carries and cancellations in the products are most likely to go wrong.
   function automatic logic [COEF_BITS-1:0] random_coef();
      int v;
      case ($urandom_range(9))
         5: begin
            v = $urandom_range(16) - 8;
         end
         6: begin
            case ($urandom_range(4))
               0: v = CMIN;
               1: v = CMAX;
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         end
         7: begin
            v = 1 << $urandom_range(COEF_BITS - 2);
            if ($urandom_range(1)) v = -v;
         end
         8: begin
            v = $urandom_range(2047) - 1024;
         end
         default: begin
            v = $urandom();
         end
      endcase
      return v[COEF_BITS-1:0];
   endfunction

   function automatic coef_set_type random_triple();
      coef_set_type k;
      int           i;
      for (i = 0; i < NUM_COEF; i++) k[i] = random_coef();
      return k;
   endfunction

   // Offers one triple on req_ and returns once it has been transferred. The
   // sender sits idle for a random number of cycles first unless the flow is
   // held steady. Valid stays high after the transfer: the next call either
   // idles, lowering it, or presents its own item in the same cycle.
   task automatic send_triple(coef_set_type k, logic [PAD_W-1:0] pad);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pad, k};
      do @(posedge clock); while (!req_tready);
      expected_points = {expected_points, intersect_planes(k)};
   endtask

   // Holds the sender off until every result already owed has arrived.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked triples: the coefficient extremes, degenerate families and
   // bit patterns, each with an exactly known answer.
   task automatic test_directed_cases();
      // All zero: everything is zero and the point is not unique.
      send_triple(planes(0, 0, 0, 0,  0, 0, 0, 0,  0, 0, 0, 0), '0);
      // Unit axes: the point is (1, 2, 3) with weight 1.
      send_triple(planes(1, 0, 0, 1,  0, 1, 0, 2,  0, 0, 1, 3), '0);
      // Every coefficient at its most negative or most positive value.
      send_triple(planes(CMIN, CMIN, CMIN, CMIN,  CMIN, CMIN, CMIN, CMIN,
                         CMIN, CMIN, CMIN, CMIN), '0);
      send_triple(planes(CMAX, CMAX, CMAX, CMAX,  CMAX, CMAX, CMAX, CMAX,
                         CMAX, CMAX, CMAX, CMAX), '0);
      // Mixed extremes, which drive the determinants towards their largest size.
      send_triple(planes(CMIN, CMAX, CMAX, CMIN,  CMAX, CMIN, CMAX, CMIN,
                         CMAX, CMAX, CMIN, CMIN), '0);
      send_triple(planes(CMAX, CMIN, CMIN, CMAX,  CMIN, CMAX, CMIN, CMAX,
                         CMIN, CMIN, CMAX, CMAX), '0);
      // Diagonal of the most negative value: weight is -2^60.
      send_triple(planes(CMIN, 0, 0, CMAX,  0, CMIN, 0, CMIN,  0, 0, CMIN, CMAX), '0);
      // Parallel planes: zero weight, and the numerators are zero as well.
      send_triple(planes(1, 2, 3, 4,  1, 2, 3, 5,  2, 4, 6, -7), '0);
      // Coincident planes: zero weight and all numerators zero.
      send_triple(planes(1, 2, 3, 4,  2, 4, 6, 8,  -3, -6, -9, -12), '0);
      // Two identical planes and a third that crosses them along a line.
      send_triple(planes(3, -1, 2, 5,  3, -1, 2, 5,  1, 1, 1, 1), '0);
      // Minus one throughout.
      send_triple(planes(-1, -1, -1, -1,  -1, -1, -1, -1,  -1, -1, -1, -1), '0);
      // Alternating bit patterns.
      send_triple(planes('h155555, 'h0aaaaa, 'h155555, 'h0aaaaa,
                         'h0aaaaa, 'h155555, 'h0aaaaa, 'h155555,
                         'h155555, 'h155555, 'h0aaaaa, 'h0aaaaa), '0);
      // The fill bits above the coefficients are set and must make no difference.
      send_triple(planes(1, 0, 0, CMAX,  0, 1, 0, CMIN,  0, 0, 1, -1), '1);
      // A signed permutation of the axes.
      send_triple(planes(0, 1, 0, 7,  0, 0, -1, -8,  1, 0, 0, 9), '0);
      // Nearly singular: large terms that cancel down to a small weight.
      send_triple(planes(CMAX, CMAX - 1, 1, 0,  CMAX - 1, CMAX - 2, 1, 1,
                         1, 1, 1, CMIN), '0);
   endtask

   task automatic test_random_planes(int count);
      int n;
      for (n = 0; n < count; n++) begin
         send_triple(random_triple(), PAD_W'($urandom_range(2**PAD_W - 1)));
      end
   endtask

   // Triples whose a, b, c rows are linearly dependent, so the weight is zero.
   // Depending on the d column the numerators vanish as well or stay nonzero.
   // Bounds are chosen so that no derived coefficient leaves the field's range.
   task automatic test_dependent_planes(int count);
      coef_set_type k;
      int           n, p, col, s, t, bound, src;
      for (n = 0; n < count; n++) begin
         k = random_triple();
         bound = (1 << (COEF_BITS - 3)) - 1;
         for (p = 0; p < 2; p++) begin
            for (col = COL_A; col <= COL_D; col++) begin
               k[p*NUM_COLS + col] = COEF_BITS'($urandom_range(2*bound) - bound);
            end
         end
         s = $urandom_range(4) - 2;
         t = $urandom_range(4) - 2;
         case ($urandom_range(3))
            0: begin
               // Third plane a combination of the other two, d included: a
               // pencil of planes through a common line.
               for (col = COL_A; col <= COL_D; col++) begin
                  k[2*NUM_COLS + col] = COEF_BITS'(s * $signed(k[col])
                                                 + t * $signed(k[NUM_COLS + col]));
               end
            end
            1: begin
               // Same combination for a, b, c only: the third d is left random.
               for (col = COL_A; col <= COL_C; col++) begin
                  k[2*NUM_COLS + col] = COEF_BITS'(s * $signed(k[col])
                                                 + t * $signed(k[NUM_COLS + col]));
               end
            end
            2: begin
               // Second plane parallel to, or the same as, the first.
               if (s == 0) s = 1;
               for (col = COL_A; col <= COL_C; col++) begin
                  k[NUM_COLS + col] = COEF_BITS'(s * $signed(k[col]));
               end
               if ($urandom_range(1)) begin
                  k[NUM_COLS + COL_D] = COEF_BITS'(s * $signed(k[COL_D]));
               end
            end
            default: begin
               // Two equal columns, or one column all zero.
               src = $urandom_range(COL_C);
               col = $urandom_range(COL_C);
               for (p = 0; p < 3; p++) begin
                  if (src == col) k[p*NUM_COLS + col] = '0;
                  else k[p*NUM_COLS + col] = k[p*NUM_COLS + src];
               end
            end
         endcase
         send_triple(k, PAD_W'($urandom_range(2**PAD_W - 1)));
      end
   endtask

   // Coefficients from -3 to 3: exact cancellation and zero weights come often.
   task automatic test_small_coefficients(int count);
      coef_set_type k;
      int           n, i, v;
      for (n = 0; n < count; n++) begin
         for (i = 0; i < NUM_COEF; i++) begin
            v = $urandom_range(6) - 3;
            k[i] = v[COEF_BITS-1:0];
         end
         send_triple(k, PAD_W'($urandom_range(2**PAD_W - 1)));
      end
   endtask

   // The sender stops part way and waits until the pipeline has emptied, then
   // carries on, so the block also sees a restart from an empty pipeline.
   task automatic test_pause_until_drained(int count);
      test_random_planes(count / 2);
      wait_for_results();
      test_random_planes(count - count / 2);
   endtask

   // A long stretch at one transfer per cycle on both channels.
   task automatic test_full_rate(int count);
      steady_flow = 1'b1;
      test_random_planes(count);
      steady_flow = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver, checking and watchdog
   // ------------------------------------------------------------------

   // The receiver stalls at random, except while the flow is held steady.
   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic void compare_field(string field, logic signed [RES_BITS-1:0] want,
                                         logic signed [RES_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fault_count++;
      end
   endfunction

   // Each result transfer is matched against the oldest point still owed.
   always @(posedge clock) begin
      hom_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: result transfer with none expected, actual %h / %b",
                     $time, rsp_tdata, rsp_tuser);
            fault_count++;
         end else begin
            want = expected_points.pop_front();
            compare_field("x_numerator", want.x_num,  rsp_tdata[DET_X*RES_BITS +: RES_BITS]);
            compare_field("y_numerator", want.y_num,  rsp_tdata[DET_Y*RES_BITS +: RES_BITS]);
            compare_field("z_numerator", want.z_num,  rsp_tdata[DET_Z*RES_BITS +: RES_BITS]);
            compare_field("weight", want.weight, rsp_tdata[DET_WEIGHT*RES_BITS +: RES_BITS]);
            compare_field("unique_res", RES_BITS'(want.unique_pt), RES_BITS'(rsp_tuser));
         end
      end
   end

   // Ends the run if neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("three_plane_intersection_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_planes(700);
      test_dependent_planes(400);
      test_small_coefficients(250);
      test_pause_until_drained(80);
      test_full_rate(200);

      // Let the last results out, then keep watching rsp_ so that any surplus
      // result transfer is caught.
      wait_for_results();
      repeat (4 * LATENCY) @(posedge clock);

      if (fault_count == 0 && expected_points.size() == 0) begin
         $display("three_plane_intersection_tb: clean");
      end else begin
         $display("three_plane_intersection_tb: errors");
      end
      $finish;
   end

endmodule

// File: three_plane_intersection.f
sv/tpi_pkg.sv
sv/tpi_minor.sv
sv/tpi_term.sv
sv/tpi_sum.sv
sv/three_plane_intersection.sv
sim/three_plane_intersection_tb.sv
